/* hdl/matrix_keypad_debounce_queue_macros.svh */
// Assertion macros shared by the keypad debounce queue modules.
`ifndef MATRIX_KEYPAD_DEBOUNCE_QUEUE_MACROS_SVH
`define MATRIX_KEYPAD_DEBOUNCE_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clock and disabled during reset.
`define MKDQ_ASSERT_IMP(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on clock and disabled during reset.
`define MKDQ_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);
`else
`define MKDQ_ASSERT_IMP(lbl, ant, cons, msg)
`define MKDQ_ASSERT_NEXT(lbl, ant, cons, msg)
`endif
`endif

/* hdl/mkdq_pkg.sv */
// Types, constants and helper functions for the keypad debounce queue.
`timescale 1ns / 1ps
package mkdq_pkg;

   // Sizing defaults and register port layout.
   localparam int QueueDepthDefault = 16;
   localparam int CsrAddrWidth      = 3;
   localparam int CsrDataWidth      = 32;
   localparam int QueueCountWidth   = 5;

   // Register indexes on the configuration port.
   localparam logic [CsrAddrWidth-3:0] REG_STABLE_THRESHOLD = '0;

   // Debounce threshold reset value and legal range.
   localparam logic [2:0] ThresholdReset = 3'd2;
   localparam logic [2:0] ThresholdMin   = 3'd1;
   localparam logic [2:0] ThresholdMax   = 3'd6;

   // Operation codes carried by a request transaction.
   localparam logic [1:0] OP_SCAN  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] column_levels;
   } req_type;

   typedef struct packed {
      logic       key_valid;
      logic [7:0] key_code;
      logic [4:0] queue_count;
      logic       key_dropped;
   } rsp_type;

   // Commands handed from the front end to the key queue.
   typedef enum logic [1:0] {
      CMD_REPORT = 2'd0,
      CMD_PUSH   = 2'd1,
      CMD_POP    = 2'd2,
      CMD_FLUSH  = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   code;
   } cmd_type;

   // ASCII code of a key position; rows are "123A", "456B", "789C", "*0#D".
   function automatic logic [7:0] key_ascii(input logic [3:0] position);
      logic [7:0] code;
      unique case (position)
         4'd0:    code = 8'h31;
         4'd1:    code = 8'h32;
         4'd2:    code = 8'h33;
         4'd3:    code = 8'h41;
         4'd4:    code = 8'h34;
         4'd5:    code = 8'h35;
         4'd6:    code = 8'h36;
         4'd7:    code = 8'h42;
         4'd8:    code = 8'h37;
         4'd9:    code = 8'h38;
         4'd10:   code = 8'h39;
         4'd11:   code = 8'h43;
         4'd12:   code = 8'h2A;
         4'd13:   code = 8'h30;
         4'd14:   code = 8'h23;
         default: code = 8'h44;
      endcase
      return code;
   endfunction

endpackage

/* hdl/matrix_keypad_debounce_queue.sv */
// A request passes through the command queue and then the result register before its result is shown.
// Throughput: one transaction per cycle while the receiver takes results, set by the debounce update in
// the front end and the one write or read of the key memory per cycle in the back end.
// Reset is synchronous: debounce state, queue pointers and count clear, threshold is 2.
// The key memory is not cleared; only written entries are ever read.
`timescale 1ns / 1ps
module matrix_keypad_debounce_queue #(
   parameter int QUEUE_DEPTH = mkdq_pkg::QueueDepthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mkdq_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mkdq_pkg::rsp_type                   rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mkdq_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [mkdq_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [mkdq_pkg::CsrDataWidth-1:0]   prdata,
   output logic                                pready
);

   logic [2:0]        threshold_ff, threshold_in;
   logic              reg_hit;
   logic              cfg_write;
   logic              cmd_full;
   logic              front_valid;
   mkdq_pkg::cmd_type front_cmd;
   logic              queue_valid;
   mkdq_pkg::cmd_type queue_cmd;
   logic              queue_take;

   // Configuration register access.
   assign pready    = 1'b1;
   assign reg_hit   = paddr[mkdq_pkg::CsrAddrWidth-1:2] == mkdq_pkg::REG_STABLE_THRESHOLD;
   assign cfg_write = psel && penable && pwrite && reg_hit;
   assign prdata    = reg_hit ? mkdq_pkg::CsrDataWidth'(threshold_ff) : '0;

   always_comb begin
      threshold_in = cfg_write ? pwdata[2:0] : threshold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= mkdq_pkg::ThresholdReset;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // Front end: decode and debounce.
   mkdq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .threshold   (threshold_ff),
      .cmd_full    (cmd_full),
      .cmd_valid   (front_valid),
      .cmd         (front_cmd)
   );

   // Command queue between the two halves.
   mkdq_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_cmd),
      .full       (cmd_full),
      .pop_valid  (queue_valid),
      .pop_data   (queue_cmd),
      .pop_take   (queue_take)
   );

   // Back end: key queue and result register.
   mkdq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (queue_valid),
      .cmd         (queue_cmd),
      .cmd_take    (queue_take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hdl/mkdq_front.sv */
// Front end: snapshot decode, debounce and command classification.
`timescale 1ns / 1ps
`include "matrix_keypad_debounce_queue_macros.svh"
module mkdq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mkdq_pkg::req_type req_payload,
   input  logic [2:0]        threshold,
   input  logic              cmd_full,
   output logic              cmd_valid,
   output mkdq_pkg::cmd_type cmd
);

   logic [7:0] last_key_ff, last_key_in;
   logic [2:0] agree_ff, agree_in;
   logic [2:0] thr;
   logic [2:0] agree_step;
   logic [3:0] position;
   logic       pressed;
   logic [7:0] cur_key;
   logic       accept;

   // A transaction is taken whenever the command queue has room.
   assign req_ready = !cmd_full;
   assign accept    = req_valid && req_ready;
   assign cmd_valid = accept;

   // Clamp the threshold to its legal range.
   always_comb begin
      if (threshold < mkdq_pkg::ThresholdMin) begin
         thr = mkdq_pkg::ThresholdMin;
      end else if (threshold > mkdq_pkg::ThresholdMax) begin
         thr = mkdq_pkg::ThresholdMax;
      end else begin
         thr = threshold;
      end
   end

   // Find the lowest pressed (low) bit of the snapshot.
   always_comb begin
      position = '0;
      pressed  = 1'b0;
      for (int i = 15; i >= 0; i--) begin
         if (!req_payload.column_levels[i]) begin
            position = 4'(i);
            pressed  = 1'b1;
         end
      end
      cur_key = pressed ? mkdq_pkg::key_ascii(position) : 8'd0;
   end

   // Debounce and classify the transaction into a queue command.
   always_comb begin
      last_key_in = last_key_ff;
      agree_in    = agree_ff;
      agree_step  = (agree_ff < thr) ? agree_ff + 3'd1 : agree_ff;
      cmd.kind    = mkdq_pkg::CMD_REPORT;
      cmd.code    = 8'd0;
      unique case (req_payload.operation)
         mkdq_pkg::OP_SCAN: begin
            if (cur_key == last_key_ff) begin
               agree_in = agree_step;
               if (agree_step == thr && cur_key != 8'd0) begin
                  // Step past the threshold so a held key is sent once.
                  agree_in = thr + 3'd1;
                  cmd.kind = mkdq_pkg::CMD_PUSH;
                  cmd.code = cur_key;
               end
            end else begin
               last_key_in = cur_key;
               agree_in    = 3'd0;
            end
         end
         mkdq_pkg::OP_POP: begin
            cmd.kind = mkdq_pkg::CMD_POP;
         end
         mkdq_pkg::OP_FLUSH: begin
            cmd.kind = mkdq_pkg::CMD_FLUSH;
         end
         default: begin
            cmd.kind = mkdq_pkg::CMD_REPORT;
         end
      endcase
   end

   // Debounce state.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_key_ff <= 8'd0;
         agree_ff    <= 3'd0;
      end else if (accept) begin
         last_key_ff <= last_key_in;
         agree_ff    <= agree_in;
      end
   end

   `MKDQ_ASSERT_IMP(a_push_has_key, cmd_valid && cmd.kind == mkdq_pkg::CMD_PUSH, cmd.code != 8'd0, "push command without a key")

endmodule

/* hdl/mkdq_cmd_queue.sv */
// Two-entry command queue between the front end and the key queue.
`timescale 1ns / 1ps
`include "matrix_keypad_debounce_queue_macros.svh"
module mkdq_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  mkdq_pkg::cmd_type push_data,
   output logic              full,
   output logic              pop_valid,
   output mkdq_pkg::cmd_type pop_data,
   input  logic              pop_take
);

   mkdq_pkg::cmd_type entries_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_data  = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push_valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_valid) - 2'(pop_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `MKDQ_ASSERT_IMP(a_no_overflow, push_valid, !full, "command queue overflow")
   `MKDQ_ASSERT_IMP(a_no_underflow, pop_take, pop_valid, "command queue underflow")

endmodule

/* hdl/mkdq_back.sv */
// Back end: key queue memory, pointers and the result register.
`timescale 1ns / 1ps
`include "matrix_keypad_debounce_queue_macros.svh"
module mkdq_back #(
   parameter int QUEUE_DEPTH = mkdq_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  mkdq_pkg::cmd_type cmd,
   output logic              cmd_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mkdq_pkg::rsp_type rsp_payload
);

   localparam int PtrWidth   = $clog2(QUEUE_DEPTH);
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);
   localparam int ExtWidth   = CountWidth + mkdq_pkg::QueueCountWidth;

   logic [7:0]            key_mem [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [ExtWidth-1:0]   count_ext;
   logic                  full, empty;
   logic                  exec;
   logic                  do_write, do_read;
   logic                  key_valid, dropped;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  key_valid_ff;
   logic                  dropped_ff;
   logic [mkdq_pkg::QueueCountWidth-1:0] queue_count_ff;
   logic [7:0]            rd_data_ff;

   // A command runs when the result register is free or being emptied.
   assign exec     = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_take = exec;
   assign full     = count_ff == CountWidth'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;

   // Queue bookkeeping for the command at the head of the command queue.
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      do_write  = 1'b0;
      do_read   = 1'b0;
      key_valid = 1'b0;
      dropped   = 1'b0;
      unique case (cmd.kind)
         mkdq_pkg::CMD_PUSH: begin
            if (full) begin
               dropped = 1'b1;
            end else begin
               do_write  = 1'b1;
               wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end
         mkdq_pkg::CMD_POP: begin
            if (!empty) begin
               do_read   = 1'b1;
               key_valid = 1'b1;
               rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         mkdq_pkg::CMD_FLUSH: begin
            rd_ptr_in = '0;
            wr_ptr_in = '0;
            count_in  = '0;
         end
         mkdq_pkg::CMD_REPORT: begin
            count_in = count_ff;
         end
      endcase
      count_ext = ExtWidth'(count_in);
   end

   // Result register handshake.
   always_comb begin
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            rd_ptr_ff <= rd_ptr_in;
            wr_ptr_ff <= wr_ptr_in;
            count_ff  <= count_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (exec) begin
         key_valid_ff   <= key_valid;
         dropped_ff     <= dropped;
         queue_count_ff <= count_ext[mkdq_pkg::QueueCountWidth-1:0];
      end
   end

   // Key memory with registered read data.
   always_ff @(posedge clock) begin
      if (exec && do_write) begin
         key_mem[wr_ptr_ff] <= cmd.code;
      end
      if (exec && do_read) begin
         rd_data_ff <= key_mem[rd_ptr_ff];
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_payload.key_valid   = key_valid_ff;
   assign rsp_payload.key_code    = key_valid_ff ? rd_data_ff : 8'd0;
   assign rsp_payload.queue_count = queue_count_ff;
   assign rsp_payload.key_dropped = dropped_ff;

   `MKDQ_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CountWidth'(QUEUE_DEPTH), "key count above depth")
   `MKDQ_ASSERT_NEXT(a_flush_empties, exec && cmd.kind == mkdq_pkg::CMD_FLUSH, count_ff == '0, "flush left keys")
   `MKDQ_ASSERT_NEXT(a_pop_returns, exec && cmd.kind == mkdq_pkg::CMD_POP && !empty, rsp_valid && key_valid_ff, "pop lost its key")

endmodule

/* test/tb_matrix_keypad_debounce_queue.sv */
// Self-checking testbench for the 4x4 keypad scanner with debounce and key queue.
`timescale 1ns / 1ps
module tb_matrix_keypad_debounce_queue;

   // The operation code that the block must treat as a no-op.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Key legends in row-major order, position 0 in the top byte.
   localparam logic [8*16-1:0] KEY_CHARS = "123A456B789C*0#D";
   localparam int RING_DEPTH = 16;
   localparam logic [15:0] NO_KEY = 16'hFFFF;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   mkdq_pkg::req_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   mkdq_pkg::rsp_type rsp_payload;
   logic psel;
   logic penable;
   logic pwrite;
   logic [mkdq_pkg::CsrAddrWidth-1:0] paddr;
   logic [mkdq_pkg::CsrDataWidth-1:0] pwdata;
   logic [mkdq_pkg::CsrDataWidth-1:0] prdata;
   logic pready;

   // Idle percentages for the sender and the receiver.
   int send_idle_pct;
   int recv_idle_pct;
   int failures;

   // Shadow copy of the block state used for prediction.
   logic [2:0] cfg_threshold;
   logic [7:0] last_decoded;
   int agree_run;
   logic [7:0] key_ring [RING_DEPTH];
   int ring_rd;
   int ring_wr;
   int ring_held;

   mkdq_pkg::rsp_type expected_rsp_q [$];

   matrix_keypad_debounce_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The run is cut off if it hangs.
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   // Code of the first pressed key in row-major order, zero when none is down.
   function automatic logic [7:0] first_pressed_char(input logic [15:0] levels);
      for (int p = 0; p < 16; p++) begin
         if (!levels[p]) return KEY_CHARS[8*(15-p) +: 8];
      end
      return 8'h00;
   endfunction

   // Register values 0 and 7 are clamped into the legal range.
   function automatic int effective_threshold();
      if (cfg_threshold < mkdq_pkg::ThresholdMin) return int'(mkdq_pkg::ThresholdMin);
      if (cfg_threshold > mkdq_pkg::ThresholdMax) return int'(mkdq_pkg::ThresholdMax);
      return int'(cfg_threshold);
   endfunction

   // Advance the shadow state by one transaction and return the result it causes.
   function automatic mkdq_pkg::rsp_type keypad_predict(input mkdq_pkg::req_type item);
      mkdq_pkg::rsp_type r;
      logic [7:0] cur;
      int thr;
      r = '0;
      thr = effective_threshold();
      case (item.operation)
         mkdq_pkg::OP_SCAN: begin
            cur = first_pressed_char(item.column_levels);
            if (cur == last_decoded) begin
               if (agree_run < thr) agree_run++;
               if (agree_run == thr && cur != 8'h00) begin
                  if (ring_held >= RING_DEPTH) begin
                     r.key_dropped = 1'b1;
                  end else begin
                     key_ring[ring_wr] = cur;
                     ring_wr = (ring_wr + 1) % RING_DEPTH;
                     ring_held++;
                  end
                  agree_run = thr + 1;
               end
            end else begin
               last_decoded = cur;
               agree_run = 0;
            end
         end
         mkdq_pkg::OP_POP: begin
            if (ring_held > 0) begin
               r.key_valid = 1'b1;
               r.key_code = key_ring[ring_rd];
               ring_rd = (ring_rd + 1) % RING_DEPTH;
               ring_held--;
            end
         end
         mkdq_pkg::OP_FLUSH: begin
            ring_rd = 0;
            ring_wr = 0;
            ring_held = 0;
         end
         default: begin
         end
      endcase
      r.queue_count = 5'(ring_held);
      return r;
   endfunction

   // Offer one transaction, with a random hold-off, and predict it once accepted.
   task automatic send_request(input logic [1:0] op, input logic [15:0] levels);
      mkdq_pkg::req_type item;
      item.operation = op;
      item.column_levels = levels;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_payload <= {2'($urandom()), 16'($urandom())};
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      expected_rsp_q.push_back(keypad_predict(item));
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic wait_queue_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic write_stable_threshold(input logic [2:0] value);
      wait_queue_idle();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {mkdq_pkg::REG_STABLE_THRESHOLD, 2'b00};
      pwdata <= {29'($urandom()), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      cfg_threshold = value;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // A snapshot whose first pressed key is at the given position.
   function automatic logic [15:0] snapshot_for(input int pos);
      logic [15:0] levels;
      levels = 16'($urandom());
      levels = levels | ((16'h1 << pos) - 16'h1);
      levels[pos] = 1'b0;
      return levels;
   endfunction

   // Random receiver stalls, changed at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare every accepted result with the oldest prediction.
   always @(posedge clock) begin : check_results
      mkdq_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result transaction: valid=%0d code=%h count=%0d dropped=%0d",
                        rsp_payload.key_valid, rsp_payload.key_code,
                        rsp_payload.queue_count, rsp_payload.key_dropped);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_payload.key_valid !== want.key_valid
                || rsp_payload.key_code !== want.key_code
                || rsp_payload.queue_count !== want.queue_count
                || rsp_payload.key_dropped !== want.key_dropped) begin
               failures++;
               if (failures <= 10) begin
                  $display("mismatch at %0t: expected valid=%0d code=%h count=%0d dropped=%0d",
                           $time, want.key_valid, want.key_code, want.queue_count,
                           want.key_dropped);
                  $display("   got valid=%0d code=%h count=%0d dropped=%0d",
                           rsp_payload.key_valid, rsp_payload.key_code,
                           rsp_payload.queue_count, rsp_payload.key_dropped);
               end
            end
         end
      end
   end

   // Empty pops, idle matrix, held keys, unused opcode, flush and pointer restart.
   task automatic test_directed_basics();
      send_request(mkdq_pkg::OP_POP, 16'h0000);
      repeat (2) send_request(mkdq_pkg::OP_SCAN, NO_KEY);
      repeat (4) send_request(mkdq_pkg::OP_SCAN, 16'h0000);
      repeat (3) send_request(mkdq_pkg::OP_SCAN, 16'h7FFF);
      send_request(OP_UNUSED, 16'h0000);
      send_request(mkdq_pkg::OP_SCAN, 16'h7FFF);
      send_request(mkdq_pkg::OP_POP, NO_KEY);
      send_request(mkdq_pkg::OP_FLUSH, NO_KEY);
      send_request(mkdq_pkg::OP_POP, NO_KEY);
      repeat (3) send_request(mkdq_pkg::OP_SCAN, 16'hBFFF);
      send_request(mkdq_pkg::OP_POP, 16'h0000);
   endtask

   // Clamped register values and a threshold lowered under a running count.
   task automatic test_threshold_config();
      write_stable_threshold(3'd7);
      repeat (7) send_request(mkdq_pkg::OP_SCAN, 16'hFFF7);
      send_request(mkdq_pkg::OP_POP, NO_KEY);
      write_stable_threshold(3'd0);
      repeat (2) send_request(mkdq_pkg::OP_SCAN, 16'hFFDF);
      send_request(mkdq_pkg::OP_POP, NO_KEY);
      write_stable_threshold(3'd6);
      repeat (4) send_request(mkdq_pkg::OP_SCAN, 16'hFBFF);
      write_stable_threshold(3'd1);
      repeat (2) send_request(mkdq_pkg::OP_SCAN, 16'hFBFF);
      repeat (2) send_request(mkdq_pkg::OP_SCAN, NO_KEY);
      send_request(mkdq_pkg::OP_POP, NO_KEY);
      write_stable_threshold(mkdq_pkg::ThresholdReset);
   endtask

   // Mostly debounced key presses with random content, plus pops, flushes and noise.
   task automatic test_random_traffic(input int item_total, input int s_pct, input int r_pct);
      int sent;
      int seg_start;
      int pop_pct;
      int choice;
      int reps;
      int pos;
      int thr;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      seg_start = -1000;
      pop_pct = 30;
      while (sent < item_total) begin
         // A new segment drains the block and picks a new threshold and pop mix.
         if (sent - seg_start >= 150) begin
            write_stable_threshold(3'($urandom_range(7)));
            case ($urandom_range(2))
               0: pop_pct = 5;
               1: pop_pct = 30;
               default: pop_pct = 55;
            endcase
            seg_start = sent;
         end
         choice = $urandom_range(99);
         if (choice < pop_pct) begin
            send_request(mkdq_pkg::OP_POP, 16'($urandom()));
            sent++;
         end else if (choice < pop_pct + 3) begin
            send_request(mkdq_pkg::OP_FLUSH, 16'($urandom()));
            sent++;
         end else if (choice < pop_pct + 5) begin
            send_request(OP_UNUSED, 16'($urandom()));
            sent++;
         end else if (choice < pop_pct + 12) begin
            send_request(2'($urandom()), 16'($urandom()));
            sent++;
         end else begin
            // A press held long enough to be accepted, now and then cut short.
            thr = effective_threshold();
            pos = $urandom_range(15);
            if ($urandom_range(9) == 0) reps = $urandom_range(thr, 1);
            else reps = thr + 1 + $urandom_range(2);
            repeat (reps) begin
               send_request(mkdq_pkg::OP_SCAN, snapshot_for(pos));
               sent++;
            end
            if ($urandom_range(3) == 0) begin
               send_request(mkdq_pkg::OP_SCAN, NO_KEY);
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      failures = 0;
      cfg_threshold = mkdq_pkg::ThresholdReset;
      last_decoded = 8'h00;
      agree_run = 0;
      ring_rd = 0;
      ring_wr = 0;
      ring_held = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_threshold_config();
      test_random_traffic(560, 12, 88);
      test_random_traffic(560, 88, 12);
      test_random_traffic(560, 0, 0);
      wait_queue_idle();

      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
